>>> src/dwrhf_pkg.sv
`timescale 1ns / 1ps

package dwrhf_pkg;

	// Field widths of the pixel and write beats
	localparam int COLOR_W = 24;
	localparam int DEPTH_W = 8;
	localparam int COL_W   = 11;

	// Stream data widths, padded to whole bytes
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;

	// Configuration registers
	localparam int CFG_W         = 12;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;
	localparam int ROW_WIDTH_RST = 640;

	localparam logic [PADDR_W-3:0] REG_ROW_WIDTH = 1'b0;
	localparam logic [PADDR_W-3:0] REG_DIRECTION = 1'b1;

	// Defaults for the top level parameters
	localparam int MAX_WIDTH_DEF   = 2048;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Shift arithmetic: num = 100*(256-d), den = 1258-d, shift in 0..21
	localparam int NUM_W     = 15;
	localparam int DEN_W     = 11;
	localparam int SHIFT_N   = 21;
	localparam int SHIFT_W   = 5;
	localparam int SHIFT_MUL = 100;
	localparam int NUM_BASE  = 256;
	localparam int DEN_BASE  = 1258;

	// Hole fill limit per pixel
	localparam int MAX_FILL = 21;
	localparam int FILL_W   = 5;

	typedef struct packed {
		logic [CFG_W-1:0] row_width;
		logic             direction;
	} cfg_t;

endpackage

>>> src/depth_warp_row_hole_fill.sv
`timescale 1ns / 1ps

// Forward warp of one image row by its depth map, with hole fill.
// Slave stream: one beat per source pixel in scan order (left to right when
// direction is 0, right to left when 1). Master stream: one beat per column
// write, the target write first and then the hole-fill writes stepping from
// the previous target; tlast marks the final write of each pixel. A pixel
// whose target falls outside the row gives no beats.
// The front takes one pixel per cycle through two pipeline stages (shift
// ratio, then target and fill span) and posts a job to a short queue. The
// back emits one write beat per cycle, so a pixel costs 1 + fills beats
// (1 to 22) at the output; the back's write count sets the sustained rate,
// and the queue absorbs fill bursts. A pixel's first beat passes both front
// stages, the queue and the output register of the back.
// A stalled receiver holds the output beat; the back, then the queue, then
// the front fill up and s_tready drops.
// Reset sets row_width to 640, direction to 0 and starts a new row; any
// register write also restarts the row. Write registers only while idle.
// Registers (APB): 0x0 row_width, 0x4 direction.

module depth_warp_row_hole_fill import dwrhf_pkg::*; #(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// slave stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [23:0] pixel_color, [31:24] depth
	// master stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [10:0] column, [34:11] write_color, pad
	output logic                 m_tlast,  // last_write
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	localparam int PW = $clog2(MAX_WIDTH + 1);
	localparam int JW = COLOR_W + 2 * PW + 1 + FILL_W;

	cfg_t               cfg_q, cfg_nxt;
	logic               wr;
	logic [PADDR_W-3:0] idx;

	logic               f_valid, f_ready, b_valid, b_ready;
	logic [JW-1:0]      f_data, b_data;
	logic [COL_W-1:0]   o_column;
	logic [COLOR_W-1:0] o_color;

	// Register file
	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel && penable && pwrite && pready;

	always_comb begin
		cfg_nxt = cfg_q;
		if (wr) begin
			unique case (idx)
				REG_ROW_WIDTH: cfg_nxt.row_width = pwdata[CFG_W-1:0];
				REG_DIRECTION: cfg_nxt.direction = pwdata[0];
				default: cfg_nxt = cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROW_WIDTH: prdata = PDATA_W'(cfg_q.row_width);
			REG_DIRECTION: prdata = PDATA_W'(cfg_q.direction);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width <= CFG_W'(ROW_WIDTH_RST);
			cfg_q.direction <= 1'b0;
		end else begin
			cfg_q <= cfg_nxt;
		end
	end

	// Front: shift ratio, target and fill span
	dwrhf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cfg_nxt  (cfg_nxt),
		.restart  (wr),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_color (s_tdata[COLOR_W-1:0]),
		.in_depth (s_tdata[COLOR_W +: DEPTH_W]),
		.job_valid(f_valid),
		.job_ready(f_ready),
		.job_data (f_data)
	);

	// Job queue
	dwrhf_queue #(.DW(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_data),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data)
	);

	// Back: write beat sequencer
	dwrhf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job_data  (b_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_column(o_column),
		.out_color (o_color),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(M_TDATA_W - COL_W - COLOR_W){1'b0}}, o_color, o_column};

endmodule

>>> src/dwrhf_front.sv
`timescale 1ns / 1ps

module dwrhf_front import dwrhf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int PW = $clog2(MAX_WIDTH + 1),
	localparam int JW = COLOR_W + 2 * PW + 1 + FILL_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cfg_t               cfg_nxt,
	input  logic               restart,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COLOR_W-1:0] in_color,
	input  logic [DEPTH_W-1:0] in_depth,
	output logic               job_valid,
	input  logic               job_ready,
	output logic [JW-1:0]      job_data
);

	localparam int TW = PW + 2;
	localparam int EW = (PW > CFG_W) ? PW : CFG_W;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [PW-1:0]      tgt;
		logic [PW-1:0]      p0;
		logic               down;
		logic [FILL_W-1:0]  fills;
	} job_t;

	// Row width saturated to 1..MAX_WIDTH
	function automatic logic [PW-1:0] eff_width(input logic [CFG_W-1:0] rw);
		logic [EW-1:0] ext;
		ext = EW'(rw);
		if (rw == '0) return PW'(1);
		if (ext > EW'(MAX_WIDTH)) return PW'(MAX_WIDTH);
		return PW'(ext);
	endfunction

	logic [PW-1:0] w, w_nxt;
	logic [PW-1:0] col_q, xp_q;
	logic          acc, row_end_in;
	logic [PW-1:0] col_next;

	logic [NUM_W-1:0] num_in;
	logic [DEN_W-1:0] den_in;

	logic               v_s1, end_s1;
	logic [COLOR_W-1:0] color_s1;
	logic [NUM_W-1:0]   num_s1;
	logic [DEN_W-1:0]   den_s1;
	logic [PW-1:0]      x_s1;

	logic [SHIFT_N-1:0] cmp;
	logic [SHIFT_W-1:0] sh;

	logic               v_s2, end_s2;
	logic [COLOR_W-1:0] color_s2;
	logic [SHIFT_W-1:0] sh_s2;
	logic [PW-1:0]      x_s2;

	logic signed [TW-1:0] x_t, sh_t, xn, xp_t, diff, mag, mag_m1;
	logic                 ok, down, rd1, rd2, leave;
	logic [FILL_W-1:0]    fills;
	job_t                 job;

	assign w     = eff_width(cfg.row_width);
	assign w_nxt = eff_width(cfg_nxt.row_width);

	// Column counter walks the row in scan order
	assign acc = in_valid && in_ready;

	always_comb begin
		if (cfg.direction) begin
			row_end_in = (col_q == '0) || (col_q >= w);
			col_next   = row_end_in ? (w - PW'(1)) : (col_q - PW'(1));
		end else begin
			row_end_in = ((PW + 1)'(col_q) + (PW + 1)'(1)) >= (PW + 1)'(w);
			col_next   = row_end_in ? '0 : (col_q + PW'(1));
		end
	end

	// Numerator and denominator of the shift ratio
	assign num_in = NUM_W'(NUM_BASE - int'(in_depth)) * NUM_W'(SHIFT_MUL);
	assign den_in = DEN_W'(DEN_BASE) - DEN_W'(in_depth);

	// Shift: floor counts k*den <= num for k >= 1, ceil counts k*den < num
	always_comb begin
		for (int k = 0; k < SHIFT_N; k++) begin
			if (cfg.direction)
				cmp[k] = num_s1 > (NUM_W'(den_s1) * NUM_W'(k));
			else
				cmp[k] = (k != 0) && (num_s1 >= (NUM_W'(den_s1) * NUM_W'(k)));
		end
		sh = SHIFT_W'($countones(cmp));
	end

	// Target, range check and fill span against the previous target
	always_comb begin
		x_t    = $signed({2'b00, x_s2});
		sh_t   = $signed(TW'(sh_s2));
		xn     = cfg.direction ? (x_t - sh_t) : (x_t + sh_t);
		ok     = !xn[TW-1] && (xn < $signed({2'b00, w}));
		xp_t   = $signed({2'b00, xp_q});
		diff   = xn - xp_t;
		down   = diff[TW-1];
		mag    = down ? -diff : diff;
		mag_m1 = mag - $signed(TW'(1));
		if (diff == '0)
			fills = '0;
		else if (mag_m1 > $signed(TW'(MAX_FILL)))
			fills = FILL_W'(MAX_FILL);
		else
			fills = FILL_W'(mag_m1);
		job.color = color_s2;
		job.tgt   = PW'(xn);
		job.p0    = down ? (xp_q - PW'(1)) : (xp_q + PW'(1));
		job.down  = down;
		job.fills = fills;
	end

	assign job_data  = job;
	assign job_valid = v_s2 && ok;

	// Pipeline flow: a rejected target leaves without a queue slot
	assign rd2      = !v_s2 || !ok || job_ready;
	assign rd1      = !v_s1 || rd2;
	assign in_ready = rd1;
	assign leave    = v_s2 && rd2;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			col_q <= '0;
			xp_q  <= '0;
		end else begin
			if (rd1) v_s1 <= in_valid;
			if (rd2) v_s2 <= v_s1;
			if (restart) begin
				col_q <= cfg_nxt.direction ? (w_nxt - PW'(1)) : '0;
				xp_q  <= cfg_nxt.direction ? w_nxt : '0;
			end else begin
				if (acc) col_q <= col_next;
				if (leave) begin
					if (end_s2)
						xp_q <= cfg.direction ? w : '0;
					else if (ok)
						xp_q <= PW'(xn);
				end
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (rd1) begin
			color_s1 <= in_color;
			num_s1   <= num_in;
			den_s1   <= den_in;
			x_s1     <= col_q;
			end_s1   <= row_end_in;
		end
		if (rd2) begin
			color_s2 <= color_s1;
			sh_s2    <= sh;
			x_s2     <= x_s1;
			end_s2   <= end_s1;
		end
	end

	// Column stays inside the row; previous target at most one past its end
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < w)
		else $error("column counter outside the row");

	a_prev_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		xp_q <= w)
		else $error("previous target beyond the row width");

endmodule

>>> src/dwrhf_queue.sv
`timescale 1ns / 1ps

module dwrhf_queue import dwrhf_pkg::*; #(
	parameter int DW    = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  logic [DW-1:0] push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output logic [DW-1:0] pop_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (do_pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem[wr_q] <= push_data;
	end

endmodule

>>> src/dwrhf_back.sv
`timescale 1ns / 1ps

module dwrhf_back import dwrhf_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int PW = $clog2(MAX_WIDTH + 1),
	localparam int JW = COLOR_W + 2 * PW + 1 + FILL_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  logic [JW-1:0]      job_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COL_W-1:0]   out_column,
	output logic [COLOR_W-1:0] out_color,
	output logic               out_last
);

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [PW-1:0]      tgt;
		logic [PW-1:0]      p0;
		logic               down;
		logic [FILL_W-1:0]  fills;
	} job_t;

	job_t               job;
	logic               ov_q, last_q, down_q, free;
	logic [FILL_W-1:0]  left_q;
	logic [PW-1:0]      pos_q, col_q;
	logic [COLOR_W-1:0] color_q;

	assign job       = job_data;
	assign free      = !ov_q || out_ready;
	assign job_ready = free && (left_q == '0);

	assign out_valid  = ov_q;
	assign out_column = COL_W'(col_q);
	assign out_color  = color_q;
	assign out_last   = last_q;

	// Beat sequencing: target write first, then fills toward the new target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			left_q <= '0;
		end else if (free) begin
			if (left_q != '0) begin
				ov_q   <= 1'b1;
				left_q <= left_q - FILL_W'(1);
			end else if (job_valid) begin
				ov_q   <= 1'b1;
				left_q <= job.fills;
			end else begin
				ov_q <= 1'b0;
			end
		end
	end

	// Output beat and fill position
	always_ff @(posedge clk) begin
		if (free) begin
			if (left_q != '0) begin
				col_q  <= pos_q;
				last_q <= left_q == FILL_W'(1);
				pos_q  <= down_q ? (pos_q - PW'(1)) : (pos_q + PW'(1));
			end else if (job_valid) begin
				col_q   <= job.tgt;
				color_q <= job.color;
				last_q  <= job.fills == '0;
				pos_q   <= job.p0;
				down_q  <= job.down;
			end
		end
	end

	// Last flag agrees with the fills still owed
	a_last_matches: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (last_q == (left_q == '0)))
		else $error("last flag disagrees with remaining fill count");

	// A stalled beat freezes the fill sequencer
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> ($stable(left_q) && $stable(pos_q)))
		else $error("fill sequencer moved while output stalled");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= FILL_W'(MAX_FILL))
		else $error("fill count beyond limit");

endmodule

>>> tb/depth_warp_row_hole_fill_tb.sv
`timescale 1ns / 1ps

module depth_warp_row_hole_fill_tb;
	import dwrhf_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 6000;
	localparam int NUM_PHASES    = 10;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [DEPTH_W-1:0] depth;
	} pixel_t;

	typedef struct packed {
		logic [COL_W-1:0]   column;
		logic [COLOR_W-1:0] color;
		logic               last;
	} write_beat_t;

	// Random phases: row width register value, direction, pixel count
	int phase_width [NUM_PHASES] = '{640, 2048, 33, 33, 4095, 2047, 1, 7, 100, 2};
	int phase_dir   [NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 0};
	int phase_count [NUM_PHASES] = '{60, 70, 60, 60, 50, 60, 10, 40, 60, 30};

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // [23:0] pixel_color, [31:24] depth
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // [10:0] column, [34:11] write_color, pad
	logic                 m_tlast;        // last_write
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [PADDR_W-1:0]   paddr    = '0;
	logic [PDATA_W-1:0]   pwdata   = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// Stimulus and expectation stores
	pixel_t      pixel_fifo[$];
	write_beat_t wr_expect[$];
	pixel_t      in_flight;

	// Warp model state
	logic [CFG_W-1:0] mdl_width_reg;
	logic             mdl_dir;
	int               mdl_col;
	int               mdl_prev;

	bit idle_on     = 1'b1;
	int holds_asked = 0;
	int holds_done  = 0;
	int hold_left   = 0;
	int src_gap     = 0;
	int sink_gap    = 0;
	int quiet       = 0;
	int fault_count = 0;
	int pixels_in   = 0;
	int writes_seen = 0;
	int cfg_writes  = 0;

	depth_warp_row_hole_fill u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Effective width: register saturated to 1..MAX_WIDTH
	function automatic int warp_width();
		int w;
		w = int'(mdl_width_reg);
		if (w == 0) w = 1;
		if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
		return w;
	endfunction

	function automatic void restart_row();
		if (!mdl_dir) begin
			mdl_col  = 0;
			mdl_prev = 0;
		end else begin
			mdl_col  = warp_width() - 1;
			mdl_prev = warp_width();
		end
	endfunction

	// Target write plus hole fill from the previous target toward the new one
	function automatic void warp_pixel(input pixel_t px);
		write_beat_t beats[MAX_FILL+1];
		int w, num, den, xn, step, p, fills, n;
		w   = warp_width();
		num = SHIFT_MUL * (NUM_BASE - int'(px.depth));
		den = DEN_BASE - int'(px.depth);
		n   = 0;
		if (!mdl_dir) xn = mdl_col + num / den;
		else          xn = mdl_col - (num + den - 1) / den;
		if (xn >= 0 && xn < w) begin
			beats[0] = '{column: COL_W'(xn), color: px.color, last: 1'b0};
			n = 1;
			step  = (xn > mdl_prev) ? 1 : -1;
			fills = 0;
			if (xn != mdl_prev) begin
				for (p = mdl_prev + step; p != xn && fills < MAX_FILL; p += step) begin
					if (p >= 0 && p < w) begin
						beats[n] = '{column: COL_W'(p), color: px.color, last: 1'b0};
						n++;
						fills++;
					end
				end
			end
			beats[n-1].last = 1'b1;
			for (int k = 0; k < n; k++) wr_expect.push_back(beats[k]);
			mdl_prev = xn;
		end
		// advance the column, wrapping at row end
		if (!mdl_dir) begin
			if (mdl_col + 1 >= w) restart_row();
			else mdl_col++;
		end else begin
			if (mdl_col == 0 || mdl_col >= w) restart_row();
			else mdl_col--;
		end
	endfunction

	function automatic int pick_gap(input bit on);
		int r;
		if (!on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void note_fault(input string what, input logic [39:0] exp_v,
			input logic [39:0] got_v);
		if (fault_count < 10)
			$display("MISMATCH %s: expected %0h, got %0h (write %0d)", what, exp_v,
				got_v, writes_seen);
		fault_count++;
	endfunction

	function automatic void check_write();
		write_beat_t want;
		logic [COL_W-1:0]   got_col;
		logic [COLOR_W-1:0] got_color;
		got_col   = m_tdata[COL_W-1:0];
		got_color = m_tdata[COL_W +: COLOR_W];
		if (wr_expect.size() == 0) begin
			note_fault("unexpected write beat", '0, 40'(m_tdata));
		end else begin
			want = wr_expect.pop_front();
			if (got_col !== want.column)
				note_fault("column", 40'(want.column), 40'(got_col));
			if (got_color !== want.color)
				note_fault("write_color", 40'(want.color), 40'(got_color));
			if (m_tlast !== want.last)
				note_fault("last_write", 40'(want.last), 40'(m_tlast));
		end
		writes_seen++;
	endfunction

	// Pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				warp_pixel(in_flight);
				pixels_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (pixel_fifo.size() > 0) begin
					in_flight = pixel_fifo.pop_front();
					s_tdata   <= {in_flight.depth, in_flight.color};
					s_tvalid  <= 1'b1;
					src_gap   = pick_gap(idle_on);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Write monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left = 0;
			sink_gap  = 0;
		end else begin
			if (m_tvalid && m_tready) check_write();
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_gap = pick_gap(idle_on);
			end
		end
	end

	// Watchdog on cycles without any beat or register access
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Watchdog: no activity for %0d cycles, %0d writes outstanding",
				quiet, wr_expect.size());
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_writes++;
	endtask

	// Both registers, then the model restarts its row
	task automatic set_row(input int width, input bit dir);
		apb_write({REG_ROW_WIDTH, 2'b00}, PDATA_W'(width));
		apb_write({REG_DIRECTION, 2'b00}, PDATA_W'(dir));
		mdl_width_reg = CFG_W'(width);
		mdl_dir       = dir;
		restart_row();
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pixel_fifo.size() != 0 || s_tvalid || wr_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_pixel(input logic [COLOR_W-1:0] color, input logic [DEPTH_W-1:0] depth);
		pixel_fifo.push_back('{color: color, depth: depth});
	endtask

	// Mostly smooth depth runs, with extremes and jumps mixed in
	task automatic push_random(input int n);
		int r, nd;
		logic [DEPTH_W-1:0] dep;
		logic [COLOR_W-1:0] col;
		dep = DEPTH_W'($urandom);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				nd = int'(dep) + int'($urandom_range(0, 8)) - 4;
				if (nd < 0) nd = 0;
				if (nd > 255) nd = 255;
				dep = DEPTH_W'(nd);
			end else if (r < 70) begin
				dep = '0;
			end else if (r < 80) begin
				dep = '1;
			end else begin
				dep = DEPTH_W'($urandom);
			end
			r = $urandom_range(0, 99);
			if (r < 5) col = '0;
			else if (r < 10) col = '1;
			else col = COLOR_W'($urandom);
			push_pixel(col, dep);
		end
	endtask

	initial begin
		mdl_width_reg = CFG_W'(ROW_WIDTH_RST);
		mdl_dir       = 1'b0;
		restart_row();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: target equal to previous, deepest shift with fill
		push_pixel(24'h000000, 8'd255);
		push_pixel(24'hFFFFFF, 8'd0);
		push_pixel(24'hA5A5A5, 8'd128);
		push_pixel(24'h5A5A5A, 8'd1);
		push_pixel(24'h123456, 8'd254);
		wait_drained();

		// Zero width counts as one column; leftward target always off the row
		set_row(0, 1'b1);
		push_pixel(24'hFFFFFF, 8'd0);
		push_pixel(24'h000000, 8'd255);
		wait_drained();

		// Single column row, rightward
		set_row(1, 1'b0);
		push_pixel(24'h00FF00, 8'd255);
		push_pixel(24'hFF00FF, 8'd0);
		push_pixel(24'h0F0F0F, 8'd200);
		wait_drained();

		// Short leftward row: wraps at row end, targets falling off the left
		set_row(14, 1'b1);
		for (int k = 0; k < 14; k++)
			push_pixel(COLOR_W'($urandom), (k % 3 == 0) ? 8'd0 : (k % 3 == 1) ? 8'd255 : 8'd128);
		wait_drained();

		for (int i = 0; i < NUM_PHASES; i++) begin
			set_row(phase_width[i], phase_dir[i][0]);
			idle_on = (i != 7);
			if (i == 1) holds_asked++;
			push_random(phase_count[i] / 2);
			// sender holds back until all writes are out
			if (i == 2) wait_drained();
			push_random(phase_count[i] - phase_count[i] / 2);
			wait_drained();
		end

		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		$display("Run covered %0d pixels and %0d column writes over %0d register writes,",
			pixels_in, writes_seen, cfg_writes);
		$display("both scan directions, widths 0 to 4095, a long output hold and idle gaps.");
		if (fault_count == 0 && wr_expect.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d writes missing", fault_count, wr_expect.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
